/* rtl/text_cell_glyph_renderer_macros.svh */
// Assertion macros shared by the glyph renderer modules.
// Expects clk and rst_n in the scope of each use.
`ifndef TEXT_CELL_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CELL_GLYPH_RENDERER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCGR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcgr_pkg.sv */
// Shared types and constants for the text cell glyph renderer.
// No dependencies; used by every module of the block except tcgr_ram.
package tcgr_pkg;

    localparam int SCREEN_WIDTH = 320;
    localparam int CELL_WIDTH   = 4;
    localparam int CELL_HEIGHT  = 8;
    localparam int TEXT_ROWS    = 30;

    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_COUNT  = 256;
    localparam int GLYPH_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GLYPH_AW     = $clog2(GLYPH_DEPTH);
    localparam int GLYPH_W      = 4;
    localparam int ADDR_W       = 17;
    localparam int DIRTY_W      = 30;
    localparam int LEFT_W       = 10;
    localparam int EDGE_W       = 13;
    localparam int PROD_W       = 22;
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 32;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic       REG_X_OFFSET = 1'b0;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_FLUSH = 2'd2
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [6:0]  cell_column;
        logic [4:0]  cell_row;
        logic [7:0]  char_code;
        logic [15:0] fore_colour;
        logic [15:0] back_colour;
        logic [2:0]  glyph_line;
        logic [3:0]  line_bits;
    } request_t;

    typedef struct packed {
        logic [16:0] pixel_address;
        logic [15:0] pixel_a;
        logic [15:0] pixel_b;
        logic [15:0] pixel_c;
        logic [15:0] pixel_d;
        logic [3:0]  write_enables;
        logic        frame_dirty;
        logic [29:0] dirty_rows;
        logic        last;
    } result_t;

    typedef struct packed {
        logic write_glyph;
        logic capture_draw;
        logic read_glyph;
        logic emit_row;
        logic emit_flush;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic row_last;
    } status_t;

endpackage

/* rtl/text_cell_glyph_renderer.sv */
// Channel     | Direction | Handshake                      | Payload
// request     | in        | request_valid / request_stall  | tcgr_pkg::request_t
// result      | out       | result_valid / result_stall    | tcgr_pkg::result_t
// config      | in        | APB (psel, penable, pwrite)    | x_offset at byte address 0
//
// A load request writes the glyph table in its request cycle. A flush request
// moves to the flush state, which emits one result. A draw request passes through
// the request cycle, one glyph table read ahead, then one result per row. The table
// is not cleared at reset; the dirty flags and control state are. A stalled result
// holds the block in its current row until it is taken.
module text_cell_glyph_renderer #(
    parameter int CELL_HEIGHT = tcgr_pkg::CELL_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        request_valid,
    output logic                        request_stall,
    input  tcgr_pkg::request_t          request,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tcgr_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcgr_pkg::CFG_AW-1:0] paddr,
    input  logic [tcgr_pkg::CFG_DW-1:0] pwdata,
    output logic [tcgr_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import tcgr_pkg::*;

    logic                busy;
    cmd_t                cmd;
    status_t             status;
    logic [3:0]          x_offset_reg;
    logic                glyph_wr_en;
    logic [GLYPH_AW-1:0] glyph_wr_addr;
    logic [GLYPH_W-1:0]  glyph_wr_data;
    logic                glyph_rd_en;
    logic [GLYPH_AW-1:0] glyph_rd_addr;
    logic [GLYPH_W-1:0]  glyph_rd_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_X_OFFSET) ? CFG_DW'(x_offset_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_X_OFFSET))
        begin
            x_offset_reg <= pwdata[3:0];
        end
    end

    assign request_stall = busy;

    tcgr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .func          (request.func),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy)
    );

    tcgr_datapath #(
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .x_offset      (x_offset_reg),
        .cmd           (cmd),
        .status        (status),
        .glyph_wr_en   (glyph_wr_en),
        .glyph_wr_addr (glyph_wr_addr),
        .glyph_wr_data (glyph_wr_data),
        .glyph_rd_en   (glyph_rd_en),
        .glyph_rd_addr (glyph_rd_addr),
        .glyph_rd_data (glyph_rd_data),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    tcgr_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .clk     (clk),
        .wr_en   (glyph_wr_en),
        .wr_addr (glyph_wr_addr),
        .wr_data (glyph_wr_data),
        .rd_en   (glyph_rd_en),
        .rd_addr (glyph_rd_addr),
        .rd_data (glyph_rd_data)
    );

endmodule

/* rtl/tcgr_ram.sv */
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module tcgr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tcgr_ctrl.sv */
// Controller state machine of the glyph renderer.
// Depends on tcgr_pkg and text_cell_glyph_renderer_macros.svh.
`include "text_cell_glyph_renderer_macros.svh"

module tcgr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    input  tcgr_pkg::func_t   func,
    input  tcgr_pkg::status_t status,
    output tcgr_pkg::cmd_t    cmd,
    output logic              busy
);
    import tcgr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request_valid)
                begin
                    unique case (func)
                        FUNC_LOAD:
                        begin
                            cmd.write_glyph = 1'b1;
                        end
                        FUNC_DRAW:
                        begin
                            cmd.capture_draw = 1'b1;
                            state_next       = ST_FETCH;
                        end
                        FUNC_FLUSH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                cmd.read_glyph = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_row   = 1'b1;
                    cmd.read_glyph = 1'b1;
                    if (status.row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `TCGR_ASSERT_NOW(a_emit_needs_slot, cmd.emit_row || cmd.emit_flush, status.slot_free, "result emitted without a free slot")
    `TCGR_ASSERT_NEXT(a_capture_then_fetch, cmd.capture_draw, cmd.read_glyph && !cmd.emit_row, "draw capture not followed by glyph fetch")
    `TCGR_ASSERT_NEXT(a_last_row_idle, cmd.emit_row && status.row_last, !busy, "controller busy after last glyph row")

endmodule

/* rtl/tcgr_datapath.sv */
// Datapath of the glyph renderer: cell geometry, row counter, dirty flags, result register.
// Depends on tcgr_pkg and text_cell_glyph_renderer_macros.svh.
`include "text_cell_glyph_renderer_macros.svh"

module tcgr_datapath #(
    parameter int CELL_HEIGHT = tcgr_pkg::CELL_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcgr_pkg::request_t              request,
    input  logic [3:0]                      x_offset,
    input  tcgr_pkg::cmd_t                  cmd,
    output tcgr_pkg::status_t               status,
    output logic                            glyph_wr_en,
    output logic [tcgr_pkg::GLYPH_AW-1:0]   glyph_wr_addr,
    output logic [tcgr_pkg::GLYPH_W-1:0]    glyph_wr_data,
    output logic                            glyph_rd_en,
    output logic [tcgr_pkg::GLYPH_AW-1:0]   glyph_rd_addr,
    input  logic [tcgr_pkg::GLYPH_W-1:0]    glyph_rd_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output tcgr_pkg::result_t               result
);
    import tcgr_pkg::*;

    localparam int CNT_W = (CELL_HEIGHT > 1) ? $clog2(CELL_HEIGHT) : 1;
    localparam int ROW_STRIDE = CELL_HEIGHT * SCREEN_WIDTH;

    logic [7:0]          code_reg;
    logic [15:0]         fore_reg;
    logic [15:0]         back_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [3:0]          enables_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIRTY_W-1:0]  dirty_rows_reg;
    logic                frame_changed_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic [LEFT_W-1:0]   left;
    logic [EDGE_W-1:0]   left_wide;
    logic [EDGE_W-1:0]   edge_gap;
    logic [PROD_W-1:0]   row_base;
    logic [ADDR_W-1:0]   base_addr;
    logic [3:0]          enables;
    logic [7:0]          draw_code;
    logic [DIRTY_W-1:0]  row_bit;
    logic [4:0]          fetch_row;

    always_comb
    begin
        left      = LEFT_W'(request.cell_column) * LEFT_W'(CELL_WIDTH) + LEFT_W'(x_offset);
        left_wide = EDGE_W'(left);
        edge_gap  = EDGE_W'(SCREEN_WIDTH) - left_wide;
        row_base  = PROD_W'(request.cell_row) * PROD_W'(ROW_STRIDE);
        base_addr = row_base[ADDR_W-1:0] + ADDR_W'(left);
        draw_code = (request.char_code < SPACE_CODE) ? SPACE_CODE : request.char_code;

        if (left_wide + EDGE_W'(CELL_WIDTH) <= EDGE_W'(SCREEN_WIDTH))
        begin
            enables = 4'b1111;
        end
        else if (left_wide >= EDGE_W'(SCREEN_WIDTH))
        begin
            enables = 4'b0000;
        end
        else
        begin
            unique case (edge_gap[1:0])
                2'd1:    enables = 4'b0001;
                2'd2:    enables = 4'b0011;
                default: enables = 4'b0111;
            endcase
        end

        if ((7'(request.cell_row) < 7'(TEXT_ROWS)) && (7'(request.cell_row) < 7'(DIRTY_W)))
        begin
            row_bit = DIRTY_W'(1) << request.cell_row;
        end
        else
        begin
            row_bit = '0;
        end
    end

    assign fetch_row = 5'(cnt_reg) + 5'(cmd.emit_row);

    assign glyph_wr_en   = cmd.write_glyph;
    assign glyph_wr_addr = {request.char_code, request.glyph_line};
    assign glyph_wr_data = request.line_bits;
    assign glyph_rd_en   = cmd.read_glyph;
    assign glyph_rd_addr = {code_reg, fetch_row[2:0]};

    assign status.slot_free = !result_valid_reg || !result_stall;
    assign status.row_last  = (cnt_reg == CNT_W'(CELL_HEIGHT - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.capture_draw)
        begin
            code_reg    <= draw_code;
            fore_reg    <= request.fore_colour;
            back_reg    <= request.back_colour;
            addr_reg    <= base_addr;
            enables_reg <= enables;
        end
        else if (cmd.emit_row)
        begin
            addr_reg <= addr_reg + ADDR_W'(SCREEN_WIDTH);
        end

        if (cmd.emit_row)
        begin
            result_reg.pixel_address <= addr_reg;
            result_reg.pixel_a       <= glyph_rd_data[3] ? fore_reg : back_reg;
            result_reg.pixel_b       <= glyph_rd_data[2] ? fore_reg : back_reg;
            result_reg.pixel_c       <= glyph_rd_data[1] ? fore_reg : back_reg;
            result_reg.pixel_d       <= glyph_rd_data[0] ? fore_reg : back_reg;
            result_reg.write_enables <= enables_reg;
            result_reg.frame_dirty   <= 1'b0;
            result_reg.dirty_rows    <= '0;
            result_reg.last          <= status.row_last;
        end
        else if (cmd.emit_flush)
        begin
            result_reg.pixel_address <= '0;
            result_reg.pixel_a       <= '0;
            result_reg.pixel_b       <= '0;
            result_reg.pixel_c       <= '0;
            result_reg.pixel_d       <= '0;
            result_reg.write_enables <= '0;
            result_reg.frame_dirty   <= frame_changed_reg;
            result_reg.dirty_rows    <= dirty_rows_reg;
            result_reg.last          <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg           <= '0;
            dirty_rows_reg    <= '0;
            frame_changed_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture_draw)
            begin
                cnt_reg           <= '0;
                dirty_rows_reg    <= dirty_rows_reg | row_bit;
                frame_changed_reg <= 1'b1;
            end
            else if (cmd.emit_row)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.emit_flush)
            begin
                dirty_rows_reg    <= '0;
                frame_changed_reg <= 1'b0;
            end

            if (cmd.emit_row || cmd.emit_flush)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TCGR_ASSERT_NOW(a_no_overwrite, cmd.emit_row || cmd.emit_flush, !(result_valid_reg && result_stall), "result register overwritten while stalled")
    `TCGR_ASSERT_NEXT(a_flush_clears, cmd.emit_flush, !frame_changed_reg && (dirty_rows_reg == '0), "dirty status not cleared by flush")
    `TCGR_ASSERT_NEXT(a_draw_marks_frame, cmd.capture_draw, frame_changed_reg, "draw did not mark the frame changed")

endmodule
